// ===== hdl/ctls_pkg.sv =====
// Shared codes for the camera/lidar timestamp synchroniser.
`default_nettype none
package ctls_pkg;
    localparam logic [2:0] ST_NO_NEW  = 3'd0;
    localparam logic [2:0] ST_MISSING = 3'd1;
    localparam logic [2:0] ST_OUTSIDE = 3'd2;
    localparam logic [2:0] ST_SYNCED  = 3'd3;
    localparam logic [2:0] ST_UNKNOWN = 3'd4;

    localparam logic [2:0] CFG_TOLERANCE = 3'd0;
    localparam logic [2:0] CFG_LIDAR_OFS = 3'd1;
    localparam logic [2:0] CFG_CAM_OFS0  = 3'd2;

    localparam int MAX_CAMERAS = 6;
    localparam int TAG_PORT_W  = 16;
    localparam int TIME_W      = 64;
endpackage
`default_nettype wire

// ===== hdl/ctls_ram.sv =====
// Generic single write port RAM with a registered read port.
`default_nettype none
module ctls_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 8
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule
`default_nettype wire

// ===== hdl/camera_lidar_timestamp_sync_top.sv =====
// Top level of the camera/lidar timestamp synchroniser.
//
// Input channel: i_valid / o_stall with op, camera_index, lidar_topic_ok,
// arrival_time_us, payload_tag and pt_size. An item is taken when i_valid
// is high and o_stall is low. Output channel: o_valid / i_stall, exactly one
// result item per input item. Configuration: i_cfg_valid / o_cfg_ready with a
// 3 bit register index; ready is always high, write only while idle.
// Each item runs through a sequencer around two RAMs (camera FIFOs and lidar
// FIFO, registered read ports). An unknown camera goes straight to the result;
// no lidar entry, an already sent lidar time or a missing camera end after the
// lidar read; else the scan reads every stored camera entry (<= 48), and a sync
// adds the drop pass over the lidar FIFO and each camera queue.
// The scan issues one camera RAM read a cycle. o_stall stays high until the
// result sits in the output register, so a stalled receiver holds one
// finished result while the next item is worked on; a second result waits
// in the final state until the register frees.
// Reset empties every FIFO, clears the sent marker, the configuration registers and the output valid.
`default_nettype none
module camera_lidar_timestamp_sync_top
    import ctls_pkg::*;
#(
    parameter int NUM_CAMERAS = 6,
    parameter int QUEUE_DEPTH = 8,
    parameter int TAG_BITS    = 16
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_valid,
    output logic                    o_stall,
    input  wire logic               i_op,
    input  wire logic [2:0]         i_camera_index,
    input  wire logic               i_lidar_topic_ok,
    input  wire logic signed [62:0] i_arrival_time_us,
    input  wire logic [15:0]        i_payload_tag,
    input  wire logic [3:0]         i_pt_size,
    output logic                    o_valid,
    input  wire logic               i_stall,
    output logic [2:0]              o_sync_status,
    output logic signed [63:0]      o_frame_time_us,
    output logic [15:0]             o_lidar_tag,
    output logic [3:0]              o_lidar_pt_size,
    output logic [15:0]             o_cam_tag_0,
    output logic [15:0]             o_cam_tag_1,
    output logic [15:0]             o_cam_tag_2,
    output logic [15:0]             o_cam_tag_3,
    output logic [15:0]             o_cam_tag_4,
    output logic [15:0]             o_cam_tag_5,
    input  wire logic               i_cfg_valid,
    output logic                    o_cfg_ready,
    input  wire logic [2:0]         i_cfg_index,
    input  wire logic [31:0]        i_cfg_data
);
    localparam int TW   = (TAG_BITS < TAG_PORT_W) ? TAG_BITS : TAG_PORT_W;
    localparam int PW   = $clog2(QUEUE_DEPTH);
    localparam int CW   = $clog2(QUEUE_DEPTH + 1);
    localparam int SW   = CW + 1;
    localparam int CIW  = (NUM_CAMERAS > 1) ? $clog2(NUM_CAMERAS) : 1;
    localparam int QW   = $clog2(NUM_CAMERAS + 1);
    localparam int CD   = NUM_CAMERAS * QUEUE_DEPTH;
    localparam int CAW  = $clog2(CD);
    localparam int CRW  = TIME_W + TW;
    localparam int LRW  = TIME_W + TW + 4;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_LRD   = 3'd1;
    localparam logic [2:0] S_LCHK  = 3'd2;
    localparam logic [2:0] S_SCAN  = 3'd3;
    localparam logic [2:0] S_DRAIN = 3'd4;
    localparam logic [2:0] S_DRD   = 3'd5;
    localparam logic [2:0] S_DCHK  = 3'd6;
    localparam logic [2:0] S_FIN   = 3'd7;

    function automatic logic [PW-1:0] slot(input logic [PW-1:0] head, input logic [CW-1:0] k);
        logic [SW-1:0] s;
        s = SW'(head) + SW'(k);
        if (s >= SW'(QUEUE_DEPTH)) begin
            s = s - SW'(QUEUE_DEPTH);
        end
        return s[PW-1:0];
    endfunction

    function automatic logic [PW-1:0] inc(input logic [PW-1:0] p);
        return (p == PW'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    // configuration registers
    logic [31:0]        r_tol;
    logic signed [31:0] r_lofs;
    logic signed [31:0] r_cofs [MAX_CAMERAS];

    logic [2:0]          r_state;
    logic [PW-1:0]       r_cam_head [NUM_CAMERAS];
    logic [CW-1:0]       r_cam_cnt  [NUM_CAMERAS];
    logic [PW-1:0]       r_lhead;
    logic [CW-1:0]       r_lcnt;
    logic signed [63:0]  r_last;
    logic                r_sent;
    logic [2:0]          r_status;
    logic signed [63:0]  r_lt;
    logic [TW-1:0]       r_ltag;
    logic [3:0]          r_ldim;
    logic signed [63:0]  r_th;
    logic [CIW-1:0]      r_c;
    logic [CW-1:0]       r_k;
    logic [QW-1:0]       r_q;
    logic                r_outside;
    logic [TW-1:0]       r_tags [NUM_CAMERAS];
    // scan pipeline: stage a waits on RAM, stage b holds the gap
    logic                r_a_v, r_a_first, r_a_last;
    logic [CIW-1:0]      r_a_c;
    logic                r_b_v, r_b_first, r_b_last;
    logic [CIW-1:0]      r_b_c;
    logic [63:0]         r_b_gap;
    logic [TW-1:0]       r_b_tag;
    logic [63:0]         r_best;
    logic [TW-1:0]       r_best_tag;
    // output register
    logic                r_o_v;
    logic [2:0]          r_o_status;
    logic signed [63:0]  r_o_time;
    logic [TW-1:0]       r_o_ltag;
    logic [3:0]          r_o_ldim;
    logic [TW-1:0]       r_o_ctag [NUM_CAMERAS];

    logic               accept;
    logic               cam_known;
    logic [CIW-1:0]     in_c;
    logic [CIW-1:0]     sel_c;
    logic [PW-1:0]      sel_head;
    logic [CW-1:0]      sel_cnt;
    logic signed [63:0] cam_ofs_ext;
    logic signed [63:0] adj_time;
    logic               cam_full, lid_full;
    logic               any_empty;
    logic               cam_we, lid_we;
    logic [CAW-1:0]     cam_waddr, cam_raddr;
    logic [PW-1:0]      lid_waddr, lid_raddr;
    logic [CRW-1:0]     cam_rdata;
    logic [LRW-1:0]     lid_rdata;
    logic signed [63:0] cam_rtime, lid_rtime;
    logic [PW-1:0]      scan_slot;
    logic               scan_last_k, scan_last_c;
    logic [CIW-1:0]     drop_c;
    logic [63:0]        new_best;
    logic [TW-1:0]      new_best_tag;
    logic               out_free;

    assign accept      = i_valid && !o_stall;
    assign o_stall     = (r_state != S_IDLE);
    assign o_cfg_ready = 1'b1;
    assign cam_known   = (i_camera_index < 3'(NUM_CAMERAS));
    assign in_c        = CIW'(i_camera_index);
    assign drop_c      = CIW'(r_q - 1'b1);
    assign out_free    = !r_o_v || !i_stall;

    // single shared read of the per-camera head and count
    always_comb begin
        if (r_state == S_IDLE) begin
            sel_c = in_c;
        end else if (r_state == S_SCAN) begin
            sel_c = r_c;
        end else begin
            sel_c = drop_c;
        end
    end
    assign sel_head = r_cam_head[sel_c];
    assign sel_cnt  = r_cam_cnt[sel_c];

    always_comb begin
        any_empty = 1'b0;
        for (int c = 0; c < NUM_CAMERAS; c++) begin
            if (r_cam_cnt[c] == '0) begin
                any_empty = 1'b1;
            end
        end
    end

    assign cam_ofs_ext = 64'(r_cofs[in_c]);
    always_comb begin
        if (i_op) begin
            adj_time = 64'(i_arrival_time_us) + 64'(r_lofs);
        end else begin
            adj_time = 64'(i_arrival_time_us) + cam_ofs_ext;
        end
    end

    assign cam_full  = (sel_cnt == CW'(QUEUE_DEPTH));
    assign lid_full  = (r_lcnt == CW'(QUEUE_DEPTH));
    assign cam_we    = accept && !i_op && cam_known;
    assign lid_we    = accept && i_op && i_lidar_topic_ok;
    assign cam_waddr = CAW'(in_c) * CAW'(QUEUE_DEPTH)
                     + CAW'(cam_full ? sel_head : slot(sel_head, sel_cnt));
    assign lid_waddr = lid_full ? r_lhead : slot(r_lhead, r_lcnt);

    assign scan_slot   = slot(sel_head, r_k);
    assign scan_last_k = (r_k == sel_cnt - 1'b1);
    assign scan_last_c = (r_c == CIW'(NUM_CAMERAS - 1));

    always_comb begin
        if (r_state == S_SCAN) begin
            cam_raddr = CAW'(r_c) * CAW'(QUEUE_DEPTH) + CAW'(scan_slot);
        end else begin
            cam_raddr = CAW'(drop_c) * CAW'(QUEUE_DEPTH) + CAW'(sel_head);
        end
        if (r_state == S_LRD) begin
            lid_raddr = slot(r_lhead, r_lcnt - 1'b1);
        end else begin
            lid_raddr = r_lhead;
        end
    end

    ctls_ram #(.WIDTH(CRW), .DEPTH(CD)) u_cam_ram (
        .i_clk   (i_clk),
        .i_we    (cam_we),
        .i_waddr (cam_waddr),
        .i_wdata ({adj_time, i_payload_tag[TW-1:0]}),
        .i_raddr (cam_raddr),
        .o_rdata (cam_rdata)
    );

    ctls_ram #(.WIDTH(LRW), .DEPTH(QUEUE_DEPTH)) u_lid_ram (
        .i_clk   (i_clk),
        .i_we    (lid_we),
        .i_waddr (lid_waddr),
        .i_wdata ({adj_time, i_payload_tag[TW-1:0], i_pt_size}),
        .i_raddr (lid_raddr),
        .o_rdata (lid_rdata)
    );

    assign cam_rtime = cam_rdata[CRW-1 -: TIME_W];
    assign lid_rtime = lid_rdata[LRW-1 -: TIME_W];

    // nearest match: first entry seeds, strictly smaller gap replaces
    always_comb begin
        if (r_b_first || (r_b_gap < r_best)) begin
            new_best     = r_b_gap;
            new_best_tag = r_b_tag;
        end else begin
            new_best     = r_best;
            new_best_tag = r_best_tag;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tol  <= '0;
            r_lofs <= '0;
            for (int c = 0; c < MAX_CAMERAS; c++) begin
                r_cofs[c] <= '0;
            end
        end else if (i_cfg_valid && o_cfg_ready) begin
            if (i_cfg_index == CFG_TOLERANCE) begin
                r_tol <= i_cfg_data;
            end else if (i_cfg_index == CFG_LIDAR_OFS) begin
                r_lofs <= i_cfg_data;
            end else begin
                r_cofs[3'(i_cfg_index - CFG_CAM_OFS0)] <= i_cfg_data;
            end
        end
    end

    // scan pipeline datapath
    always_ff @(posedge i_clk) begin
        r_b_first <= r_a_first;
        r_b_last  <= r_a_last;
        r_b_c     <= r_a_c;
        r_b_tag   <= cam_rdata[TW-1:0];
        if (cam_rtime >= r_lt) begin
            r_b_gap <= cam_rtime - r_lt;
        end else begin
            r_b_gap <= r_lt - cam_rtime;
        end
        if (r_b_v) begin
            r_best     <= new_best;
            r_best_tag <= new_best_tag;
            if (r_b_last) begin
                r_tags[r_b_c] <= new_best_tag;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_lhead <= '0;
            r_lcnt  <= '0;
            r_last  <= '0;
            r_sent  <= 1'b0;
            r_a_v   <= 1'b0;
            r_b_v   <= 1'b0;
            r_o_v   <= 1'b0;
            for (int c = 0; c < NUM_CAMERAS; c++) begin
                r_cam_head[c] <= '0;
                r_cam_cnt[c]  <= '0;
            end
        end else begin
            r_a_v <= 1'b0;
            r_b_v <= r_a_v;
            // load a finished result, or drop the one the receiver took
            if ((r_state == S_FIN) && out_free) begin
                r_o_v <= 1'b1;
            end else if (r_o_v && !i_stall) begin
                r_o_v <= 1'b0;
            end
            if (r_b_v && r_b_last && (new_best > 64'(r_tol))) begin
                r_outside <= 1'b1;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        if (!i_op && !cam_known) begin
                            r_status <= ST_UNKNOWN;
                            r_state  <= S_FIN;
                        end else begin
                            if (cam_we) begin
                                if (cam_full) begin
                                    r_cam_head[in_c] <= inc(sel_head);
                                end else begin
                                    r_cam_cnt[in_c] <= sel_cnt + 1'b1;
                                end
                            end
                            if (lid_we) begin
                                if (lid_full) begin
                                    r_lhead <= inc(r_lhead);
                                end else begin
                                    r_lcnt <= r_lcnt + 1'b1;
                                end
                            end
                            r_state <= S_LRD;
                        end
                    end
                end
                S_LRD: begin
                    if (r_lcnt == '0) begin
                        r_status <= ST_NO_NEW;
                        r_state  <= S_FIN;
                    end else begin
                        r_state <= S_LCHK;
                    end
                end
                S_LCHK: begin
                    r_lt      <= lid_rtime;
                    r_ltag    <= lid_rdata[TW+3:4];
                    r_ldim    <= lid_rdata[3:0];
                    r_c       <= '0;
                    r_k       <= '0;
                    r_outside <= 1'b0;
                    if (r_sent && (r_last == lid_rtime)) begin
                        r_status <= ST_NO_NEW;
                        r_state  <= S_FIN;
                    end else if (any_empty) begin
                        r_status <= ST_MISSING;
                        r_state  <= S_FIN;
                    end else begin
                        r_state <= S_SCAN;
                    end
                end
                S_SCAN: begin
                    // one camera RAM read a cycle, camera by camera
                    r_a_v     <= 1'b1;
                    r_a_c     <= r_c;
                    r_a_first <= (r_k == '0);
                    r_a_last  <= scan_last_k;
                    if (scan_last_k) begin
                        r_k <= '0;
                        r_c <= r_c + 1'b1;
                        if (scan_last_c) begin
                            r_state <= S_DRAIN;
                        end
                    end else begin
                        r_k <= r_k + 1'b1;
                    end
                end
                S_DRAIN: begin
                    if (!r_a_v && !r_b_v) begin
                        if (r_outside) begin
                            r_status <= ST_OUTSIDE;
                            r_state  <= S_FIN;
                        end else begin
                            r_status <= ST_SYNCED;
                            r_last   <= r_lt;
                            r_sent   <= 1'b1;
                            r_th     <= r_lt - 64'(r_tol);
                            r_q      <= '0;
                            r_state  <= S_DRD;
                        end
                    end
                end
                S_DRD: begin
                    // queue 0 is the lidar FIFO, queue q is camera q-1
                    if (((r_q == '0) && (r_lcnt == '0)) ||
                        ((r_q != '0) && (sel_cnt == '0))) begin
                        if (r_q == QW'(NUM_CAMERAS)) begin
                            r_state <= S_FIN;
                        end else begin
                            r_q <= r_q + 1'b1;
                        end
                    end else begin
                        r_state <= S_DCHK;
                    end
                end
                S_DCHK: begin
                    if ((r_q == '0) && (lid_rtime < r_th)) begin
                        r_lhead <= inc(r_lhead);
                        r_lcnt  <= r_lcnt - 1'b1;
                        r_state <= S_DRD;
                    end else if ((r_q != '0) && (cam_rtime < r_th)) begin
                        r_cam_head[drop_c] <= inc(sel_head);
                        r_cam_cnt[drop_c]  <= sel_cnt - 1'b1;
                        r_state            <= S_DRD;
                    end else if (r_q == QW'(NUM_CAMERAS)) begin
                        r_state <= S_FIN;
                    end else begin
                        r_q     <= r_q + 1'b1;
                        r_state <= S_DRD;
                    end
                end
                S_FIN: begin
                    if (out_free) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    // output payload, zero unless synced
    always_ff @(posedge i_clk) begin
        if ((r_state == S_FIN) && out_free) begin
            r_o_status <= r_status;
            if (r_status == ST_SYNCED) begin
                r_o_time <= r_lt;
                r_o_ltag <= r_ltag;
                r_o_ldim <= r_ldim;
                for (int c = 0; c < NUM_CAMERAS; c++) begin
                    r_o_ctag[c] <= r_tags[c];
                end
            end else begin
                r_o_time <= '0;
                r_o_ltag <= '0;
                r_o_ldim <= '0;
                for (int c = 0; c < NUM_CAMERAS; c++) begin
                    r_o_ctag[c] <= '0;
                end
            end
        end
    end

    logic [TAG_PORT_W-1:0] cam_tag_out [MAX_CAMERAS];
    always_comb begin
        for (int c = 0; c < MAX_CAMERAS; c++) begin
            cam_tag_out[c] = '0;
        end
        for (int c = 0; c < NUM_CAMERAS; c++) begin
            cam_tag_out[c] = TAG_PORT_W'(r_o_ctag[c]);
        end
    end

    assign o_valid           = r_o_v;
    assign o_sync_status     = r_o_status;
    assign o_frame_time_us   = r_o_time;
    assign o_lidar_tag       = TAG_PORT_W'(r_o_ltag);
    assign o_lidar_pt_size   = r_o_ldim;
    assign o_cam_tag_0       = cam_tag_out[0];
    assign o_cam_tag_1       = cam_tag_out[1];
    assign o_cam_tag_2       = cam_tag_out[2];
    assign o_cam_tag_3       = cam_tag_out[3];
    assign o_cam_tag_4       = cam_tag_out[4];
    assign o_cam_tag_5       = cam_tag_out[5];
endmodule
`default_nettype wire

// ===== hdl/ctls_checker.sv =====
// Port level checks for the timestamp synchroniser, bound to the top level.
`default_nettype none
module ctls_checker
    import ctls_pkg::*;
(
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        o_valid,
    input wire logic        i_stall,
    input wire logic [2:0]  o_sync_status,
    input wire logic [63:0] o_frame_time_us,
    input wire logic [15:0] o_lidar_tag,
    input wire logic [3:0]  o_lidar_pt_size
);
    a_status_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_sync_status <= ST_UNKNOWN))
        else $error("status code out of range");

    a_zero_unless_synced: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (o_sync_status != ST_SYNCED)) |->
        ((o_frame_time_us == '0) && (o_lidar_tag == '0) && (o_lidar_pt_size == '0)))
        else $error("payload not cleared on unsynced result");

    a_hold_stalled: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_stall) |=> (o_valid && $stable(o_sync_status)))
        else $error("stalled result changed");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result present after reset");
endmodule

bind camera_lidar_timestamp_sync_top ctls_checker u_ctls_checker (
    .i_clk             (i_clk),
    .i_rst_n           (i_rst_n),
    .o_valid           (o_valid),
    .i_stall           (i_stall),
    .o_sync_status     (o_sync_status),
    .o_frame_time_us   (o_frame_time_us),
    .o_lidar_tag       (o_lidar_tag),
    .o_lidar_pt_size   (o_lidar_pt_size)
);
`default_nettype wire

// ===== test/camera_lidar_timestamp_sync_top_tb.sv =====
// Self-checking testbench for the camera/lidar timestamp synchroniser top level.
`default_nettype none
module camera_lidar_timestamp_sync_top_tb;
    import ctls_pkg::*;

    localparam int NCAM      = 6;
    localparam int DEPTH     = 8;
    localparam int STALL_MAX = 20000;   // cycles with work pending but no item moved

    typedef struct {
        bit        op;
        bit [2:0]  cam;
        bit        topic_ok;
        bit [62:0] t;
        bit [15:0] tag;
        bit [3:0]  dim;
    } arrival_t;

    typedef struct {
        bit [2:0]  status;
        bit [63:0] ftime;
        bit [15:0] ltag;
        bit [3:0]  ldim;
        bit [15:0] ctag [NCAM];
    } frame_t;

    // Clock and reset.
    logic i_clk = 1'b1;
    logic i_rst_n = 1'b0;
    always begin
        i_clk = 1'b1;
        #2;
        i_clk = 1'b0;
        #2;
    end

    // Block ports; every input starts at a known value.
    logic               i_valid = 1'b0;
    logic               o_stall;
    logic               i_op = 1'b0;
    logic [2:0]         i_camera_index = '0;
    logic               i_lidar_topic_ok = 1'b0;
    logic signed [62:0] i_arrival_time_us = '0;
    logic [15:0]        i_payload_tag = '0;
    logic [3:0]         i_pt_size = '0;
    logic               o_valid;
    logic               i_stall = 1'b0;
    logic [2:0]         o_sync_status;
    logic signed [63:0] o_frame_time_us;
    logic [15:0]        o_lidar_tag;
    logic [3:0]         o_lidar_pt_size;
    logic [15:0]        o_cam_tag_0, o_cam_tag_1, o_cam_tag_2;
    logic [15:0]        o_cam_tag_3, o_cam_tag_4, o_cam_tag_5;
    logic               i_cfg_valid = 1'b0;
    logic               o_cfg_ready;
    logic [2:0]         i_cfg_index = '0;
    logic [31:0]        i_cfg_data = '0;

    camera_lidar_timestamp_sync_top i_dut (.*);

    // Predictor state: per-camera FIFOs, lidar FIFO, sent marker, registers.
    // Two-state variables start at zero, which is the reset state.
    longint    cam_time [NCAM][DEPTH];
    bit [15:0] cam_tag  [NCAM][DEPTH];
    int        cam_head [NCAM];
    int        cam_cnt  [NCAM];
    longint    lid_time [DEPTH];
    bit [15:0] lid_tag  [DEPTH];
    bit [3:0]  lid_dim  [DEPTH];
    int        lid_head, lid_cnt;
    longint    sent_time;
    bit        sent_flag;
    bit [31:0] tol_reg;
    longint    lid_ofs;
    longint    cam_ofs [NCAM];

    arrival_t  arrivals[$];     // items waiting for the driver
    frame_t    frames_due[$];   // results predicted, not yet seen
    int        mismatches;
    int        status_seen [5];
    int        items_in;
    int        cycle_cnt;
    int        idle_run;

    function automatic bit [63:0] time_gap(longint a, longint b);
        return (a >= b) ? 64'(a - b) : 64'(b - a);
    endfunction

    // Drop every entry older than th from the head of each FIFO.
    function automatic void drop_older(longint th);
        while (lid_cnt > 0 && lid_time[lid_head] < th) begin
            lid_head = (lid_head + 1) % DEPTH;
            lid_cnt--;
        end
        for (int c = 0; c < NCAM; c++)
            while (cam_cnt[c] > 0 && cam_time[c][cam_head[c]] < th) begin
                cam_head[c] = (cam_head[c] + 1) % DEPTH;
                cam_cnt[c]--;
            end
    endfunction

    // Update the FIFOs with one arrival and work out the result item it gives.
    function automatic frame_t predict_frame(arrival_t a);
        frame_t    r;
        longint    t, lt;
        int        s, li, bs;
        bit [63:0] best, d;
        bit        outside;
        bit [15:0] tags [NCAM];
        r.status = ST_NO_NEW;
        r.ftime = '0;
        r.ltag = '0;
        r.ldim = '0;
        for (int c = 0; c < NCAM; c++) r.ctag[c] = '0;
        t = longint'($signed(a.t));
        if (!a.op) begin
            if (a.cam >= MAX_CAMERAS) begin
                r.status = ST_UNKNOWN;
                return r;
            end
            if (cam_cnt[a.cam] >= DEPTH) begin
                cam_head[a.cam] = (cam_head[a.cam] + 1) % DEPTH;
                cam_cnt[a.cam]--;
            end
            s = (cam_head[a.cam] + cam_cnt[a.cam]) % DEPTH;
            cam_time[a.cam][s] = t + cam_ofs[a.cam];
            cam_tag[a.cam][s] = a.tag;
            cam_cnt[a.cam]++;
        end else if (a.topic_ok) begin
            if (lid_cnt >= DEPTH) begin
                lid_head = (lid_head + 1) % DEPTH;
                lid_cnt--;
            end
            s = (lid_head + lid_cnt) % DEPTH;
            lid_time[s] = t + lid_ofs;
            lid_tag[s] = a.tag;
            lid_dim[s] = a.dim;
            lid_cnt++;
        end
        if (lid_cnt == 0) return r;
        li = (lid_head + lid_cnt - 1) % DEPTH;
        lt = lid_time[li];
        if (sent_flag && sent_time == lt) return r;
        for (int c = 0; c < NCAM; c++)
            if (cam_cnt[c] == 0) begin
                r.status = ST_MISSING;
                return r;
            end
        outside = 1'b0;
        for (int c = 0; c < NCAM; c++) begin
            // nearest entry wins; on a tie the older one is kept
            bs = cam_head[c];
            best = time_gap(cam_time[c][bs], lt);
            for (int k = 1; k < cam_cnt[c]; k++) begin
                s = (cam_head[c] + k) % DEPTH;
                d = time_gap(cam_time[c][s], lt);
                if (d < best) begin
                    best = d;
                    bs = s;
                end
            end
            if (best > {32'b0, tol_reg}) outside = 1'b1;
            tags[c] = cam_tag[c][bs];
        end
        if (outside) begin
            r.status = ST_OUTSIDE;
            return r;
        end
        r.status = ST_SYNCED;
        r.ftime = 64'(lt);
        r.ltag = lid_tag[li];
        r.ldim = lid_dim[li];
        for (int c = 0; c < NCAM; c++) r.ctag[c] = tags[c];
        sent_time = lt;
        sent_flag = 1'b1;
        drop_older(lt - longint'({32'b0, tol_reg}));
        return r;
    endfunction

    // Driver: hold the item until taken, then idle or advance at random.
    always @(posedge i_clk) begin
        arrival_t a;
        bit       quiet;
        cycle_cnt <= cycle_cnt + 1;
        quiet = (cycle_cnt > 3000 && cycle_cnt < 7000);
        if (i_rst_n && (!i_valid || !o_stall)) begin
            if (i_valid) begin
                a.op = i_op;
                a.cam = i_camera_index;
                a.topic_ok = i_lidar_topic_ok;
                a.t = i_arrival_time_us;
                a.tag = i_payload_tag;
                a.dim = i_pt_size;
                frames_due.insert(frames_due.size(), predict_frame(a));
                items_in++;
            end
            if (arrivals.size() > 0 && (quiet || $urandom_range(99) >= 24)) begin
                a = arrivals[0];
                arrivals.delete(0);
                i_valid <= 1'b1;
                i_op <= a.op;
                i_camera_index <= a.cam;
                i_lidar_topic_ok <= a.topic_ok;
                i_arrival_time_us <= a.t;
                i_payload_tag <= a.tag;
                i_pt_size <= a.dim;
            end else begin
                i_valid <= 1'b0;
            end
        end
    end

    // Monitor: check each result item against the oldest prediction.
    always @(posedge i_clk) begin
        frame_t     e;
        logic [15:0] got [NCAM];
        if (i_rst_n && o_valid && !i_stall) begin
            got = '{o_cam_tag_0, o_cam_tag_1, o_cam_tag_2,
                    o_cam_tag_3, o_cam_tag_4, o_cam_tag_5};
            if (frames_due.size() == 0) begin
                $error("result item with nothing expected, status %0d", o_sync_status);
                mismatches++;
            end else begin
                e = frames_due[0];
                frames_due.delete(0);
                if (e.status <= ST_UNKNOWN) status_seen[e.status]++;
                if (o_sync_status !== e.status) begin
                    $error("sync_status: expected %0d, got %0d", e.status, o_sync_status);
                    mismatches++;
                end
                if (o_frame_time_us !== e.ftime) begin
                    $error("frame_time_us: expected %0d, got %0d",
                           $signed(e.ftime), o_frame_time_us);
                    mismatches++;
                end
                if (o_lidar_tag !== e.ltag) begin
                    $error("lidar_tag: expected %h, got %h", e.ltag, o_lidar_tag);
                    mismatches++;
                end
                if (o_lidar_pt_size !== e.ldim) begin
                    $error("lidar_pt_size: expected %0d, got %0d", e.ldim, o_lidar_pt_size);
                    mismatches++;
                end
                for (int c = 0; c < NCAM; c++)
                    if (got[c] !== e.ctag[c]) begin
                        $error("cam_tag_%0d: expected %h, got %h", c, e.ctag[c], got[c]);
                        mismatches++;
                    end
            end
        end
        // receiver back-pressure, same idling rate and quiet stretch as the sender
        i_stall <= !(cycle_cnt > 3000 && cycle_cnt < 7000) && ($urandom_range(99) < 24);
    end

    // Watchdog: count cycles with work outstanding but no item moving.
    always @(posedge i_clk) begin
        if ((i_valid && !o_stall) || (o_valid && !i_stall) ||
            (arrivals.size() == 0 && !i_valid && frames_due.size() == 0)) begin
            idle_run <= 0;
        end else begin
            idle_run <= idle_run + 1;
        end
        if (idle_run >= STALL_MAX) begin
            $display("end of test: mismatches");
            $finish;
        end
    end

    // Hold until the sender has nothing left and every result has come.
    task automatic wait_drained();
        do @(posedge i_clk);
        while (arrivals.size() != 0 || i_valid || frames_due.size() != 0);
        repeat (4) @(posedge i_clk);
    endtask

    // Write one register and mirror it into the predictor.
    task automatic write_reg(bit [2:0] idx, bit [31:0] val);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= val;
        do @(posedge i_clk);
        while (!o_cfg_ready);
        case (idx)
            CFG_TOLERANCE: tol_reg = val;
            CFG_LIDAR_OFS: lid_ofs = longint'($signed(val));
            default:       cam_ofs[idx - CFG_CAM_OFS0] = longint'($signed(val));
        endcase
    endtask

    function automatic arrival_t mk_item(bit op, bit [2:0] cam, bit ok, longint t,
                                         bit [15:0] tag, bit [3:0] dim);
        arrival_t a;
        a.op = op;
        a.cam = cam;
        a.topic_ok = ok;
        a.t = t[62:0];
        a.tag = tag;
        a.dim = dim;
        return a;
    endfunction

    // Append one item to the sender's queue.
    function automatic void enqueue(arrival_t a);
        arrivals.insert(arrivals.size(), a);
    endfunction

    function automatic bit [15:0] rtag();
        return 16'($urandom);
    endfunction

    // Queue one frame: the cameras around base (offsets undone; now and then one camera is skipped), plus a lidar item.
    task automatic queue_frame(longint base, int jit);
        int     order [NCAM];
        int     j, lpos, skip;
        longint jt;
        for (int c = 0; c < NCAM; c++) order[c] = c;
        order.shuffle();
        lpos = $urandom_range(NCAM);
        skip = ($urandom_range(9) == 0) ? $urandom_range(NCAM - 1) : -1;
        for (int k = 0; k <= NCAM; k++) begin
            if (k == lpos)
                enqueue(mk_item(1'b1, 3'($urandom), $urandom_range(9) != 0,
                                base - lid_ofs, rtag(), 4'($urandom)));
            if (k < NCAM && order[k] != skip) begin
                j = $urandom_range(2 * jit);
                jt = longint'(j) - jit;
                enqueue(mk_item(1'b0, 3'(order[k]), 1'($urandom),
                                base - cam_ofs[order[k]] + jt,
                                rtag(), 4'($urandom)));
            end
        end
    endtask

    initial begin
        longint    base, t;
        int        jit, n;
        bit [31:0] tol_v;
        bit [31:0] ofs_v [8];

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: unknown cameras, foreign lidar, missing cameras, exact sync,
        // already emitted lidar time, extreme timestamps and field values.
        enqueue(mk_item(1'b0, 3'd7, 1'b1, 64'h7fff_ffff_ffff_ffff, 16'hffff, 4'hf));
        enqueue(mk_item(1'b0, 3'd6, 1'b0, 0, 16'h0000, 4'h0));
        enqueue(mk_item(1'b1, 3'd0, 1'b0, 100, 16'h1234, 4'h3));
        enqueue(mk_item(1'b1, 3'd5, 1'b1, 100, 16'hffff, 4'hf));
        for (int c = 0; c < NCAM; c++)
            enqueue(mk_item(1'b0, 3'(c), 1'b1, 100, 16'(16'ha000 + c), 4'h0));
        enqueue(mk_item(1'b1, 3'd0, 1'b1, 100, 16'h0001, 4'h1));
        enqueue(mk_item(1'b0, 3'd0, 1'b1, 101, 16'h0002, 4'h0));
        enqueue(mk_item(1'b1, 3'd7, 1'b1, 64'h3fff_ffff_ffff_ffff, 16'h8000, 4'h8));
        enqueue(mk_item(1'b1, 3'd0, 1'b1, 64'h4000_0000_0000_0000, 16'h7fff, 4'h7));
        enqueue(mk_item(1'b0, 3'd1, 1'b1, 64'h4000_0000_0000_0000, 16'h5555, 4'h0));
        enqueue(mk_item(1'b0, 3'd2, 1'b1, 64'h3fff_ffff_ffff_ffff, 16'haaaa, 4'h0));
        // camera 0 entries at 99 and 101, equally far from a later lidar time 100 that was already sent
        enqueue(mk_item(1'b0, 3'd0, 1'b1, 99, 16'h00aa, 4'h0));
        enqueue(mk_item(1'b1, 3'd0, 1'b1, 100, 16'h00bb, 4'h2));
        wait_drained();

        // Random phases, each with its own register setting; the sender
        // pauses at every boundary until all results are in.
        for (int p = 0; p < 6; p++) begin
            case (p)
                0: begin
                    tol_v = 32'd5;
                    foreach (ofs_v[i]) ofs_v[i] = '0;
                end
                1: begin
                    tol_v = 32'hffff_ffff;
                    foreach (ofs_v[i]) ofs_v[i] = 32'h8000_0000;
                end
                2: begin
                    tol_v = '0;
                    foreach (ofs_v[i]) ofs_v[i] = 32'h7fff_ffff;
                end
                default: begin
                    tol_v = $urandom_range(2000);
                    foreach (ofs_v[i]) ofs_v[i] = $urandom;
                end
            endcase
            write_reg(CFG_TOLERANCE, tol_v);
            write_reg(CFG_LIDAR_OFS, ofs_v[0]);
            for (int c = 0; c < NCAM; c++) write_reg(3'(CFG_CAM_OFS0 + c), ofs_v[c + 1]);
            i_cfg_valid <= 1'b0;

            base = longint'({$urandom, 8'h00});
            n = 0;
            while (n < 170) begin
                if ($urandom_range(99) < 78) begin
                    jit = (tol_v < 1000) ? int'(tol_v) : 1000;
                    // step outside tolerance now and then
                    if ($urandom_range(5) == 0) jit = jit + 50;
                    queue_frame(base, jit);
                    base += $urandom_range(1, 3000);
                    n += NCAM + 1;
                end else begin
                    t = ($urandom_range(19) == 0) ? longint'({$urandom, $urandom})
                                                  : base + $urandom_range(4000) - 2000;
                    enqueue(mk_item(1'($urandom), 3'($urandom), 1'($urandom),
                                    t, rtag(), 4'($urandom)));
                    n++;
                end
            end
            wait_drained();
        end

        repeat (300) @(posedge i_clk);
        $display("Covered %0d items over 7 register settings: synced %0d, outside %0d,",
                 items_in, status_seen[ST_SYNCED], status_seen[ST_OUTSIDE]);
        $display("missing camera %0d, no new lidar %0d, unknown camera %0d.",
                 status_seen[ST_MISSING], status_seen[ST_NO_NEW], status_seen[ST_UNKNOWN]);
        if (mismatches == 0 && frames_due.size() == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end
endmodule
`default_nettype wire
